### hw/rtl/rwc_pkg.sv
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared widths, defaults and command codes of the reachable weight collector.
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int CMD_W          = 2;
  localparam int NODE_IN_W      = 6;
  localparam int WEIGHT_IN_W    = 16;
  localparam int SUM_W          = 22;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 24;

  localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_WGT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTORE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COLLECT  = 2'd3;

endpackage

### hw/rtl/rwc_store.sv
// ----------------------------------------------------------------------------
// rwc_store
// Single-port-write, single-port-read synchronous memory; read data is
// registered. A per-entry valid bit makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
module rwc_store #(
  parameter int DEPTH = rwc_pkg::DEF_MAX_NODES,
  parameter int WIDTH = rwc_pkg::DEF_WEIGHT_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] q;
  logic             q_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q     <= mem[raddr];
      q_vld <= vld[raddr];
    end
  end

  assign rdata = q_vld ? q : '0;

endmodule

### hw/rtl/reachable_weight_collector.sv
// ----------------------------------------------------------------------------
// reachable_weight_collector
// Graph store with per-node weights; sums and clears the weights of the
// connected component around a source node.
// ----------------------------------------------------------------------------
// Usage: commands arrive as beats on the s_axis channel, the kind in tuser.
// Add edge, set weight and restore return nothing; collect returns one beat
// on m_axis with the collected sum. The block takes one command at a time:
//   set weight  a single write of the loaded weight store
//   add edge    read-modify-write of two adjacency rows
//   restore     copy sweep of the loaded weights, one entry per cycle
//   collect     one pick and one absorb step per reached node, then done;
//               the walk is set by the adjacency memory read loop, one row
//               and one weight read per node. Out-of-range sources go to done.
// The result sits in an output register; the next command is accepted while
// it waits. A collect that finishes while that register is still full holds
// until m_axis_tready frees it.
// Reset clears control state and the per-entry valid bits of all memories,
// so every store reads as zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module reachable_weight_collector #(
  parameter int MAX_NODES   = rwc_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = rwc_pkg::DEF_WEIGHT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [5:0] node_a, [11:6] node_b, [27:12] weight_value, [31:28] zero
  input  logic [rwc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [rwc_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [21:0] collected_sum, [23:22] zero
  output logic [rwc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EDGE_A  = 3'd1;
  localparam logic [2:0] S_EDGE_B  = 3'd2;
  localparam logic [2:0] S_RESTORE = 3'd3;
  localparam logic [2:0] S_PICK    = 3'd4;
  localparam logic [2:0] S_ABSORB  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  function automatic logic [MAX_NODES-1:0] node_bit(input logic [AW-1:0] n);
    return {{(MAX_NODES-1){1'b0}}, 1'b1} << n;
  endfunction

  logic [2:0]                     state;
  logic [AW-1:0]                  node_x;
  logic [AW-1:0]                  node_y;
  logic [CW-1:0]                  cnt;
  logic [MAX_NODES-1:0]           visited;
  logic [MAX_NODES-1:0]           pending;
  logic [rwc_pkg::SUM_W-1:0]      sum;
  logic [rwc_pkg::SUM_W-1:0]      m_sum;
  logic                           m_valid;

  logic [rwc_pkg::CMD_W-1:0]      cmd;
  logic [rwc_pkg::NODE_IN_W-1:0]  node_a;
  logic [rwc_pkg::NODE_IN_W-1:0]  node_b;
  logic [rwc_pkg::WEIGHT_IN_W-1:0] weight_value;
  logic [WEIGHT_BITS-1:0]         w_in;
  logic                           s_fire;
  logic                           a_ok;
  logic                           b_ok;
  logic [AW-1:0]                  a_idx;
  logic [AW-1:0]                  b_idx;
  logic [MAX_NODES-1:0]           lsb;
  logic [AW-1:0]                  pick_idx;
  logic [MAX_NODES-1:0]           fresh;

  logic                           adj_we, adj_re;
  logic [AW-1:0]                  adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0]           adj_wdata, adj_rdata;
  logic                           ld_we, ld_re;
  logic [AW-1:0]                  ld_waddr, ld_raddr;
  logic [WEIGHT_BITS-1:0]         ld_wdata, ld_rdata;
  logic                           wk_we, wk_re;
  logic [AW-1:0]                  wk_waddr, wk_raddr;
  logic [WEIGHT_BITS-1:0]         wk_wdata, wk_rdata;

  assign cmd          = s_axis_tuser;
  assign node_a       = s_axis_tdata[5:0];
  assign node_b       = s_axis_tdata[11:6];
  assign weight_value = s_axis_tdata[27:12];
  assign w_in         = WEIGHT_BITS'(weight_value);
  assign a_ok         = int'(node_a) < MAX_NODES;
  assign b_ok         = int'(node_b) < MAX_NODES;
  assign a_idx        = node_a[AW-1:0];
  assign b_idx        = node_b[AW-1:0];

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = rwc_pkg::OUT_TDATA_W'(m_sum);

  // isolate the lowest pending node, then encode it
  assign lsb = pending & (~pending + {{(MAX_NODES-1){1'b0}}, 1'b1});

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (lsb[i]) begin
        pick_idx = pick_idx | AW'(i);
      end
    end
  end

  assign fresh = adj_rdata & ~visited;

  always_comb begin
    adj_we = 1'b0; adj_waddr = node_x; adj_wdata = adj_rdata;
    adj_re = 1'b0; adj_raddr = node_x;
    ld_we  = 1'b0; ld_waddr  = a_idx;  ld_wdata  = w_in;
    ld_re  = 1'b0; ld_raddr  = cnt[AW-1:0];
    wk_we  = 1'b0; wk_waddr  = node_x; wk_wdata  = '0;
    wk_re  = 1'b0; wk_raddr  = pick_idx;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (cmd)
            rwc_pkg::CMD_ADD_EDGE: begin
              adj_re    = a_ok && b_ok;
              adj_raddr = a_idx;
            end
            rwc_pkg::CMD_SET_WGT: begin
              ld_we = a_ok;
            end
            rwc_pkg::CMD_RESTORE: begin
              ld_re    = 1'b1;
              ld_raddr = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_EDGE_A: begin
        adj_we    = 1'b1;
        adj_waddr = node_x;
        adj_wdata = adj_rdata | node_bit(node_y);
        adj_re    = 1'b1;
        adj_raddr = node_y;
      end
      S_EDGE_B: begin
        adj_we    = 1'b1;
        adj_waddr = node_y;
        adj_wdata = adj_rdata | node_bit(node_x);
      end
      S_RESTORE: begin
        wk_we    = 1'b1;
        wk_waddr = AW'(cnt - 1'b1);
        wk_wdata = ld_rdata;
        ld_re    = (cnt != CW'(MAX_NODES));
      end
      S_PICK: begin
        adj_re    = (pending != '0);
        adj_raddr = pick_idx;
        wk_re     = (pending != '0);
      end
      S_ABSORB: begin
        // clear the weight just taken
        wk_we    = 1'b1;
        wk_waddr = node_x;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      if (m_valid && m_axis_tready && state != S_DONE) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            node_x <= a_idx;
            node_y <= b_idx;
            case (cmd)
              rwc_pkg::CMD_ADD_EDGE: begin
                if (a_ok && b_ok) begin
                  state <= S_EDGE_A;
                end
              end
              rwc_pkg::CMD_RESTORE: begin
                cnt   <= CW'(1);
                state <= S_RESTORE;
              end
              rwc_pkg::CMD_COLLECT: begin
                sum <= '0;
                if (a_ok) begin
                  visited <= node_bit(a_idx);
                  pending <= node_bit(a_idx);
                  state   <= S_PICK;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE_A: state <= S_EDGE_B;
        S_EDGE_B: state <= S_IDLE;
        S_RESTORE: begin
          if (cnt == CW'(MAX_NODES)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PICK: begin
          if (pending == '0) begin
            state <= S_DONE;
          end else begin
            pending <= pending & ~lsb;
            node_x  <= pick_idx;
            state   <= S_ABSORB;
          end
        end
        S_ABSORB: begin
          sum     <= sum + rwc_pkg::SUM_W'(wk_rdata);
          visited <= visited | fresh;
          pending <= pending | fresh;
          state   <= S_PICK;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_valid || m_axis_tready) begin
            m_valid <= 1'b1;
            m_sum   <= sum;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rwc_store #(.DEPTH(MAX_NODES), .WIDTH(MAX_NODES), .AW(AW)) u_adj (
    .clk(clk), .rst(rst),
    .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
  );

  rwc_store #(.DEPTH(MAX_NODES), .WIDTH(WEIGHT_BITS), .AW(AW)) u_loaded (
    .clk(clk), .rst(rst),
    .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
    .re(ld_re), .raddr(ld_raddr), .rdata(ld_rdata)
  );

  rwc_store #(.DEPTH(MAX_NODES), .WIDTH(WEIGHT_BITS), .AW(AW)) u_working (
    .clk(clk), .rst(rst),
    .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .re(wk_re), .raddr(wk_raddr), .rdata(wk_rdata)
  );

endmodule

### hw/rtl/rwc_checker.sv
// ----------------------------------------------------------------------------
// rwc_checker
// Port-level checks of the reachable weight collector, bound to the top level.
// ----------------------------------------------------------------------------
module rwc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [rwc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [rwc_pkg::CMD_W-1:0]       s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  // an accepted collect takes the block out of idle
  a_collect_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && s_axis_tvalid && s_axis_tready && s_axis_tuser == rwc_pkg::CMD_COLLECT
    |=> !s_axis_tready)
    else $error("collect accepted without leaving idle");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[rwc_pkg::OUT_TDATA_W-1:rwc_pkg::SUM_W] == '0)
    else $error("result padding bits set");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind reachable_weight_collector rwc_checker u_rwc_checker (.*);
